// ===== rtl/egas_pkg.sv =====
// Shared constants for the epsilon-greedy action selector.
`timescale 1ns / 1ps

package egas_pkg;

    // Default configuration
    localparam int NUM_ACTIONS_DEF = 4;
    localparam int Q_WIDTH_DEF     = 16;

    // Epsilon register: fraction of 65536, 65536 means always explore
    localparam int              EPS_W     = 17;
    localparam logic [EPS_W-1:0] EPS_RESET = 17'd6554;

    // Random draws
    localparam int DRAW_W = 16;

    // Remainder pipeline: draw bits retired per stage
    localparam int REM_BITS_PER_STAGE = 4;
    localparam int REM_STAGES         = DRAW_W / REM_BITS_PER_STAGE;

endpackage

// ===== rtl/egas_if.sv =====
// Request and result channel interfaces of the epsilon-greedy action selector.
`timescale 1ns / 1ps

interface egas_req_if import egas_pkg::*; #(
    parameter int NUM_ACTIONS = NUM_ACTIONS_DEF,
    parameter int Q_WIDTH     = Q_WIDTH_DEF
) ();
    logic                                valid;
    logic                                ready;
    logic [NUM_ACTIONS-1:0]              legal_mask;
    logic [NUM_ACTIONS-1:0][Q_WIDTH-1:0] q_value;
    logic [DRAW_W-1:0]                   explore_draw;
    logic [DRAW_W-1:0]                   pick_draw;

    modport source (output valid, legal_mask, q_value, explore_draw, pick_draw, input ready);
    modport sink   (input valid, legal_mask, q_value, explore_draw, pick_draw, output ready);
endinterface

interface egas_res_if import egas_pkg::*; #(
    parameter int NUM_ACTIONS = NUM_ACTIONS_DEF
) ();
    localparam int IDX_W = $clog2(NUM_ACTIONS);

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] chosen_action;
    logic             explored;
    logic             no_legal_action;

    modport source (output valid, chosen_action, explored, no_legal_action, input ready);
    modport sink   (input valid, chosen_action, explored, no_legal_action, output ready);
endinterface

// ===== rtl/egas_lane.sv =====
// One compare lane: flags its action when it is legal and no legal action beats it.
`timescale 1ns / 1ps

module egas_lane #(
    parameter int NUM_ACTIONS = 4,
    parameter int Q_WIDTH     = 16,
    parameter int LANE        = 0
) (
    input  logic [NUM_ACTIONS-1:0]              legal_mask,
    input  logic [NUM_ACTIONS-1:0][Q_WIDTH-1:0] q_value,
    output logic                                is_max
);

    // Independent compares against every other legal action
    always_comb
    begin
        is_max = legal_mask[LANE];
        for (int j = 0; j < NUM_ACTIONS; j++)
        begin
            if (j != LANE && legal_mask[j] &&
                ($signed(q_value[LANE]) < $signed(q_value[j])))
            begin
                is_max = 1'b0;
            end
        end
    end

endmodule

// ===== rtl/egas_rem.sv =====
// Pipelined restoring remainder: draw mod a small candidate count.
`timescale 1ns / 1ps

module egas_rem import egas_pkg::*; #(
    parameter int DIV_W  = 3,
    parameter int SIDE_W = 6
) (
    input  logic                  clk,
    input  logic [REM_STAGES-1:0] en,
    input  logic [DRAW_W-1:0]     dividend,
    input  logic [DIV_W-1:0]      divisor,
    input  logic [SIDE_W-1:0]     side_in,
    output logic [DIV_W-1:0]      rem,
    output logic [DIV_W-1:0]      divisor_out,
    output logic [SIDE_W-1:0]     side_out
);

    logic [DIV_W-1:0]  rem_reg  [REM_STAGES];
    logic [DRAW_W-1:0] draw_reg [REM_STAGES];
    logic [DIV_W-1:0]  div_reg  [REM_STAGES];
    logic [SIDE_W-1:0] side_reg [REM_STAGES];

    for (genvar s = 0; s < REM_STAGES; s++)
    begin : g_stage
        logic [DIV_W-1:0]  rem_in;
        logic [DRAW_W-1:0] draw_in;
        logic [DIV_W-1:0]  div_in;
        logic [SIDE_W-1:0] side_stage_in;
        logic [DIV_W-1:0]  rem_next;
        logic [DRAW_W-1:0] draw_next;

        if (s == 0)
        begin : g_first
            assign rem_in        = '0;
            assign draw_in       = dividend;
            assign div_in        = divisor;
            assign side_stage_in = side_in;
        end
        else
        begin : g_rest
            assign rem_in        = rem_reg[s-1];
            assign draw_in       = draw_reg[s-1];
            assign div_in        = div_reg[s-1];
            assign side_stage_in = side_reg[s-1];
        end

        // Retire REM_BITS_PER_STAGE draw bits, MSB first; partial remainder stays below divisor
        always_comb
        begin
            logic [DIV_W:0] trial;
            rem_next  = rem_in;
            draw_next = draw_in;
            for (int b = 0; b < REM_BITS_PER_STAGE; b++)
            begin
                trial     = {rem_next, draw_next[DRAW_W-1]};
                draw_next = draw_next << 1;
                if (trial >= {1'b0, div_in})
                begin
                    trial = trial - {1'b0, div_in};
                end
                rem_next = trial[DIV_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s]  <= rem_next;
                draw_reg[s] <= draw_next;
                div_reg[s]  <= div_in;
                side_reg[s] <= side_stage_in;
            end
        end
    end

    assign rem         = rem_reg[REM_STAGES-1];
    assign divisor_out = div_reg[REM_STAGES-1];
    assign side_out    = side_reg[REM_STAGES-1];

endmodule

// ===== rtl/egas_merge.sv =====
// Merge stage: picks the candidate whose ascending rank equals the target.
`timescale 1ns / 1ps

module egas_merge #(
    parameter int NUM_ACTIONS = 4,
    parameter int CNT_W       = 3,
    parameter int IDX_W       = 2
) (
    input  logic [NUM_ACTIONS-1:0] cand,
    input  logic [CNT_W-1:0]       target,
    output logic [IDX_W-1:0]       idx
);

    logic [NUM_ACTIONS-1:0] hit;

    // Per-lane rank: candidates below this lane
    for (genvar i = 0; i < NUM_ACTIONS; i++)
    begin : g_rank
        localparam logic [NUM_ACTIONS-1:0] LOW_MASK = NUM_ACTIONS'((1 << i) - 1);
        assign hit[i] = cand[i] && (CNT_W'($countones(cand & LOW_MASK)) == target);
    end

    // At most one lane hits; OR the indices together
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < NUM_ACTIONS; i++)
        begin
            if (hit[i])
            begin
                idx = idx | IDX_W'(i);
            end
        end
    end

endmodule

// ===== rtl/epsilon_greedy_action_select.sv =====
// Top level of the epsilon-greedy action selector.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  req     | in        | valid / ready       | legal_mask, q_value[], explore_draw, pick_draw
//  res     | out       | valid / ready       | chosen_action, explored, no_legal_action
//  cfg     | in        | cfg_wr_en           | cfg_wr_data (epsilon)
//
// One request per cycle sustained while res is ready. The stages are the lane
// compare stage, the candidate count stage, the pipelined remainder
// (DRAW_W / REM_BITS_PER_STAGE stages) and the output register.
// Every stage advances when it is empty or the next one advances, so bubbles
// close up while res is stalled. Reset clears the valid bits and loads epsilon
// with its default; payload registers are not reset.
`timescale 1ns / 1ps

module epsilon_greedy_action_select import egas_pkg::*; #(
    parameter int NUM_ACTIONS = NUM_ACTIONS_DEF,
    parameter int Q_WIDTH     = Q_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [EPS_W-1:0] cfg_wr_data,
    egas_req_if.sink         req,
    egas_res_if.source       res
);

    localparam int CNT_W      = $clog2(NUM_ACTIONS + 1);
    localparam int IDX_W      = $clog2(NUM_ACTIONS);
    localparam int NUM_STAGES = REM_STAGES + 3;
    localparam int SIDE_W     = NUM_ACTIONS + 2;

    // Epsilon register
    logic [EPS_W-1:0] eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (cfg_wr_en)
        begin
            eps_reg <= cfg_wr_data;
        end
    end

    // Stage valid bits and enables
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_en;

    always_comb
    begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || res.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign valid_next = {valid_reg[NUM_STAGES-2:0], req.valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    assign req.ready = stage_en[0];

    // Stage 1: compare lanes and explore decision
    logic [NUM_ACTIONS-1:0] is_max_lane;
    logic [NUM_ACTIONS-1:0] is_max_reg;
    logic [NUM_ACTIONS-1:0] legal_reg;
    logic                   explore_reg;
    logic [DRAW_W-1:0]      pick_reg;

    for (genvar i = 0; i < NUM_ACTIONS; i++)
    begin : g_lane
        egas_lane #(
            .NUM_ACTIONS (NUM_ACTIONS),
            .Q_WIDTH     (Q_WIDTH),
            .LANE        (i)
        ) u_lane (
            .legal_mask (req.legal_mask),
            .q_value    (req.q_value),
            .is_max     (is_max_lane[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            is_max_reg  <= is_max_lane;
            legal_reg   <= req.legal_mask;
            explore_reg <= ({1'b0, req.explore_draw} < eps_reg);
            pick_reg    <= req.pick_draw;
        end
    end

    // Stage 2: candidate set and its count
    logic [NUM_ACTIONS-1:0] cand_next;
    logic [NUM_ACTIONS-1:0] cand_reg;
    logic [CNT_W-1:0]       div_reg;
    logic                   none_reg;
    logic                   explore2_reg;
    logic [DRAW_W-1:0]      pick2_reg;

    assign cand_next = explore_reg ? legal_reg : is_max_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            cand_reg     <= cand_next;
            div_reg      <= CNT_W'($countones(cand_next));
            none_reg     <= (legal_reg == '0);
            explore2_reg <= explore_reg;
            pick2_reg    <= pick_reg;
        end
    end

    // Remainder pipeline: pick draw mod candidate count
    logic [CNT_W-1:0]  rem_out;
    logic [CNT_W-1:0]  div_out;
    logic [SIDE_W-1:0] side_out;

    egas_rem #(
        .DIV_W  (CNT_W),
        .SIDE_W (SIDE_W)
    ) u_rem (
        .clk         (clk),
        .en          (stage_en[NUM_STAGES-2:2]),
        .dividend    (pick2_reg),
        .divisor     (div_reg),
        .side_in     ({cand_reg, explore2_reg, none_reg}),
        .rem         (rem_out),
        .divisor_out (div_out),
        .side_out    (side_out)
    );

    logic                   none_d;
    logic                   explore_d;
    logic [NUM_ACTIONS-1:0] cand_d;
    logic [IDX_W-1:0]       pick_idx;

    assign none_d    = side_out[0];
    assign explore_d = side_out[1];
    assign cand_d    = side_out[SIDE_W-1:2];

    // Merge: select the ranked candidate
    egas_merge #(
        .NUM_ACTIONS (NUM_ACTIONS),
        .CNT_W       (CNT_W),
        .IDX_W       (IDX_W)
    ) u_merge (
        .cand   (cand_d),
        .target (rem_out),
        .idx    (pick_idx)
    );

    // Output register
    logic [IDX_W-1:0] chosen_reg;
    logic             explored_reg;
    logic             no_legal_reg;

    always_ff @(posedge clk)
    begin
        if (stage_en[NUM_STAGES-1])
        begin
            chosen_reg   <= none_d ? '0 : pick_idx;
            explored_reg <= explore_d && !none_d;
            no_legal_reg <= none_d;
        end
    end

    assign res.valid           = valid_reg[NUM_STAGES-1];
    assign res.chosen_action   = chosen_reg;
    assign res.explored        = explored_reg;
    assign res.no_legal_action = no_legal_reg;

    // Checks
    a_accept_fills_stage1 : assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> valid_reg[0])
        else $error("accepted request did not enter stage 1");

    a_nonempty_count : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[1] && !none_reg |-> div_reg != '0)
        else $error("legal actions present but candidate count is zero");

    a_rem_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NUM_STAGES-2] && !none_d |-> rem_out < div_out)
        else $error("remainder not below candidate count");

    a_empty_result : assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.no_legal_action |-> res.chosen_action == '0 && !res.explored)
        else $error("empty mask result carries an action or explore flag");

endmodule
